// File: sv/rdib_pkg.sv
// Package with the shared types, codes, constants and helper functions of the ray binner.
package rdib_pkg;

	localparam int EXP_TABLE_SIZE = 256;
	localparam int EXP_SPAN = 16;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	// exp(-EXP_SPAN / EXP_TABLE_SIZE) in Q0.30, from the truncated alternating series.
	localparam logic [63:0] EXP_RATIO = 64'd1008687096;
	localparam logic [39:0] ACC_MAX = 40'hFF_FFFF_FFFF;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_RAY = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] CFG_SMOOTHING_MODE = 3'd0;
	localparam logic [2:0] CFG_POINT_COUNT = 3'd1;
	localparam logic [2:0] CFG_HIT_THRESHOLD = 3'd2;
	localparam logic [2:0] CFG_SMOOTH_THRESHOLD = 3'd3;
	localparam logic [2:0] CFG_KERNEL_GAIN = 3'd4;
	localparam logic [2:0] CFG_KERNEL_INV_WIDTH = 3'd5;

	typedef struct packed {
		logic [1:0] opcode;
		logic [9:0] point_index;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [15:0] ray_energy;
	} in_item_t;

	typedef struct packed {
		logic [9:0] read_index;
		logic [39:0] intensity;
		logic saturated;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_READ_RD, ST_READ_OUT, ST_GE, ST_GE2,
		ST_DOT_X, ST_DOT_Y, ST_DOT_Z, ST_DOT_CMP,
		ST_K_SQ, ST_K_U, ST_K_A, ST_K_E, ST_K_D, ST_K_EX, ST_K_M1, ST_K_M2, ST_K_WR,
		ST_DIV_GO, ST_DIV, ST_H_RD, ST_H_ACC, ST_H_WR
	} state_t;

	typedef logic [30:0] exp_tab_t [0:EXP_TABLE_SIZE];

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [63:0] v;
		v = Q30_ONE;
		t[0] = v[30:0];
		for (int k = 1; k <= EXP_TABLE_SIZE; k++) begin
			v = (v * EXP_RATIO + (64'd1 << 29)) >> 30;
			t[k] = v[30:0];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	// Entry layout: bit 40 is the sticky saturation flag, bits 39:0 the accumulator.
	function automatic logic [40:0] acc_add(input logic [39:0] acc, input logic flag,
			input logic [41:0] amount);
		logic [42:0] sum;
		sum = {3'b000, acc} + {1'b0, amount};
		if (sum > {3'b000, ACC_MAX}) begin
			return {1'b1, ACC_MAX};
		end
		return {flag, sum[39:0]};
	endfunction

endpackage

// File: sv/rdib_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rdib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: sv/rdib_div.sv
// Restoring divider that produces one quotient bit per cycle.
module rdib_div import rdib_pkg::*; #(
	parameter int DIVIDEND_W = 24,
	parameter int DIVISOR_W = 11
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIVIDEND_W-1:0] dividend,
	input logic [DIVISOR_W-1:0] divisor,
	output logic busy,
	output logic [DIVIDEND_W-1:0] quotient
);
	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic [CW-1:0] cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] diff;
	logic fits;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff = trial - {1'b0, dsr_q};
	assign fits = trial >= {1'b0, dsr_q};
	assign busy = cnt_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DIVIDEND_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end
endmodule

// File: sv/ray_direction_intensity_binner_top.sv
// Top level of the ray binner: sequencer, shared multiplier, stores and result register.
//
// Items arrive on in_valid/in_ready/in_data; read results leave on
// out_valid/out_ready/out_data. Configuration is written through cfg_write,
// cfg_index and cfg_data at any time and takes effect at once.
// After reset the accumulator store is cleared, one slot a cycle, through
// all MAX_POINTS slots; in_ready stays low during that pass.
// A load is written in the cycle it is accepted. A read passes ST_READ_RD
// and ST_READ_OUT to the result register and holds there while the receiver
// stalls; the next item can be taken while that result awaits transfer.
// A ray passes ST_DOT_X, ST_DOT_Y, ST_DOT_Z and ST_DOT_CMP for each direction
// in use, as the single multiplier forms three products per direction. Hard
// mode then runs the divider and ST_H_RD, ST_H_ACC and ST_H_WR per hit for
// the accumulator update; smoothing mode adds ST_K_SQ to ST_K_WR for each
// direction above the threshold, reusing the same multiplier five times.
// in_ready is high only while no item is in progress.
module ray_direction_intensity_binner_top import rdib_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam int PTR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic mode_q;
	logic [10:0] pc_q;
	logic signed [15:0] hthr_q, sthr_q;
	logic [31:0] gain_q, invw_q;

	logic [CNT_W-1:0] j_q, c_q, i_q, n_w, j_nxt, c_nxt, i_nxt;
	logic [PTR_W-1:0] clr_q, slot_q;
	logic signed [15:0] x_q, y_q, z_q;
	logic [15:0] energy_q;
	logic [9:0] idx_q;
	logic idx_ok_q, idx_ok_w;
	logic [63:0] mul_q;
	logic signed [33:0] dot_q, dot_w, thr_w;
	logic hit_w, big_q, ezero_q;
	logic [47:0] ge_q;
	logic [30:0] u_q, tabk_q, d_q, e_w;
	logic [11:0] fr_q;
	logic [16:0] e16_q;
	logic [40:0] t_q;
	logic [23:0] share_q;
	logic [32:0] mag_w;
	logic [60:0] udiff_w;
	logic [7:0] k_w;
	out_item_t out_q;
	logic out_valid_q;

	logic mul_en;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;

	logic dir_we, dir_re, acc_we, acc_re, hit_we, hit_re;
	logic [PTR_W-1:0] dir_raddr, acc_waddr, acc_raddr;
	logic [40:0] acc_wdata, acc_rdata;
	logic [47:0] dir_rdata;
	logic [PTR_W-1:0] hit_rdata;
	logic div_start, div_busy;
	logic [23:0] div_quo;

	assign n_w = ({21'b0, pc_q} > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pc_q);
	assign idx_ok_w = 32'(in_data.point_index) < MAX_POINTS;
	assign j_nxt = j_q + CNT_W'(1);
	assign i_nxt = i_q + CNT_W'(1);
	assign thr_w = mode_q ? $signed({{3{sthr_q[15]}}, sthr_q, 15'b0})
		: $signed({{3{hthr_q[15]}}, hthr_q, 15'b0});
	assign dot_w = dot_q + $signed(mul_q[33:0]);
	assign hit_w = dot_w > thr_w;
	assign c_nxt = c_q + CNT_W'(hit_w);
	assign mag_w = dot_q[33] ? 33'(-dot_q) : dot_q[32:0];
	assign udiff_w = {1'b1, 60'b0} - {1'b0, mul_q[59:0]};
	assign k_w = mul_q[49:42];
	assign e_w = tabk_q - mul_q[42:12];
	assign mul_p = mul_a * mul_b;
	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	rdib_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_dir_ram (
		.clk(clk), .we(dir_we), .waddr(PTR_W'(in_data.point_index)),
		.wdata({in_data.dir_x, in_data.dir_y, in_data.dir_z}),
		.re(dir_re), .raddr(dir_raddr), .rdata(dir_rdata)
	);

	rdib_ram #(.WIDTH(41), .DEPTH(MAX_POINTS)) u_acc_ram (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
	);

	rdib_ram #(.WIDTH(PTR_W), .DEPTH(MAX_POINTS)) u_hit_ram (
		.clk(clk), .we(hit_we), .waddr(c_q[PTR_W-1:0]), .wdata(j_q[PTR_W-1:0]),
		.re(hit_re), .raddr(i_q[PTR_W-1:0]), .rdata(hit_rdata)
	);

	rdib_div #(.DIVIDEND_W(24), .DIVISOR_W(CNT_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend({energy_q, 8'b0}),
		.divisor(c_q), .busy(div_busy), .quotient(div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == PTR_W'(MAX_POINTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					priority if (in_data.opcode == OP_READ) state_d = ST_READ_RD;
					else if (in_data.opcode == OP_RAY && n_w != '0) state_d = ST_GE;
					else state_d = ST_IDLE;
				end
			end
			ST_READ_RD: state_d = ST_READ_OUT;
			ST_READ_OUT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			ST_GE: state_d = ST_GE2;
			ST_GE2: state_d = ST_DOT_X;
			ST_DOT_X: state_d = ST_DOT_Y;
			ST_DOT_Y: state_d = ST_DOT_Z;
			ST_DOT_Z: state_d = ST_DOT_CMP;
			ST_DOT_CMP: begin
				priority if (mode_q && hit_w) state_d = ST_K_SQ;
				else if (j_nxt < n_w) state_d = ST_DOT_X;
				else if (mode_q || c_nxt == '0) state_d = ST_IDLE;
				else state_d = ST_DIV_GO;
			end
			ST_K_SQ: state_d = ST_K_U;
			ST_K_U: state_d = ST_K_A;
			ST_K_A: state_d = ST_K_E;
			ST_K_E: state_d = ST_K_D;
			ST_K_D: state_d = ST_K_EX;
			ST_K_EX: state_d = ST_K_M1;
			ST_K_M1: state_d = ST_K_M2;
			ST_K_M2: state_d = ST_K_WR;
			ST_K_WR: state_d = (j_q < n_w) ? ST_DOT_X : ST_IDLE;
			ST_DIV_GO: state_d = ST_DIV;
			ST_DIV: begin
				if (!div_busy) state_d = ST_H_RD;
			end
			ST_H_RD: state_d = ST_H_ACC;
			ST_H_ACC: state_d = ST_H_WR;
			ST_H_WR: state_d = (i_nxt < c_q) ? ST_H_RD : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dir_we = 1'b0;
		dir_re = 1'b0;
		dir_raddr = '0;
		acc_we = 1'b0;
		acc_waddr = '0;
		acc_wdata = '0;
		acc_re = 1'b0;
		acc_raddr = '0;
		hit_we = 1'b0;
		hit_re = 1'b0;
		mul_en = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				acc_we = 1'b1;
				acc_waddr = clr_q;
			end
			ST_IDLE: begin
				dir_we = in_valid && in_data.opcode == OP_LOAD && idx_ok_w;
			end
			ST_READ_RD: begin
				acc_re = 1'b1;
				acc_raddr = PTR_W'(idx_q);
			end
			ST_GE: begin
				mul_en = 1'b1;
				mul_a = $signed({1'b0, gain_q});
				mul_b = $signed({17'b0, energy_q});
				dir_re = 1'b1;
			end
			ST_DOT_X: begin
				mul_en = 1'b1;
				mul_a = 33'(x_q);
				mul_b = 33'($signed(dir_rdata[47:32]));
			end
			ST_DOT_Y: begin
				mul_en = 1'b1;
				mul_a = 33'(y_q);
				mul_b = 33'($signed(dir_rdata[31:16]));
			end
			ST_DOT_Z: begin
				mul_en = 1'b1;
				mul_a = 33'(z_q);
				mul_b = 33'($signed(dir_rdata[15:0]));
				dir_re = 1'b1;
				dir_raddr = j_nxt[PTR_W-1:0];
			end
			ST_DOT_CMP: begin
				hit_we = !mode_q && hit_w;
			end
			ST_K_SQ: begin
				mul_en = 1'b1;
				mul_a = $signed({3'b0, mag_w[29:0]});
				mul_b = $signed({3'b0, mag_w[29:0]});
				acc_re = 1'b1;
				acc_raddr = slot_q;
			end
			ST_K_A: begin
				mul_en = 1'b1;
				mul_a = $signed({2'b0, u_q});
				mul_b = $signed({1'b0, invw_q});
			end
			ST_K_D: begin
				mul_en = 1'b1;
				mul_a = $signed({2'b0, d_q});
				mul_b = $signed({21'b0, fr_q});
			end
			ST_K_M1: begin
				mul_en = 1'b1;
				mul_a = $signed({9'b0, ge_q[47:24]});
				mul_b = $signed({16'b0, e16_q});
			end
			ST_K_M2: begin
				mul_en = 1'b1;
				mul_a = $signed({9'b0, ge_q[23:0]});
				mul_b = $signed({16'b0, e16_q});
			end
			ST_K_WR: begin
				acc_we = 1'b1;
				acc_waddr = slot_q;
				acc_wdata = acc_add(acc_rdata[39:0], acc_rdata[40],
					{1'b0, t_q} + {25'b0, mul_q[40:24]});
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
			end
			ST_H_RD: begin
				hit_re = 1'b1;
			end
			ST_H_ACC: begin
				acc_re = 1'b1;
				acc_raddr = hit_rdata;
			end
			ST_H_WR: begin
				acc_we = 1'b1;
				acc_waddr = hit_rdata;
				acc_wdata = acc_add(acc_rdata[39:0], acc_rdata[40], {18'b0, share_q});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			mode_q <= 1'b0;
			pc_q <= 11'd1024;
			hthr_q <= 16'sd32440;
			sthr_q <= 16'sd29000;
			gain_q <= 32'd65536;
			invw_q <= 32'd65536;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + PTR_W'(1);
			if (state_q == ST_READ_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_SMOOTHING_MODE: mode_q <= cfg_data[0];
					CFG_POINT_COUNT: pc_q <= cfg_data[10:0];
					CFG_HIT_THRESHOLD: hthr_q <= cfg_data[15:0];
					CFG_SMOOTH_THRESHOLD: sthr_q <= cfg_data[15:0];
					CFG_KERNEL_GAIN: gain_q <= cfg_data;
					CFG_KERNEL_INV_WIDTH: invw_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) mul_q <= mul_p[63:0];
		unique case (state_q)
			ST_IDLE: begin
				x_q <= in_data.dir_x;
				y_q <= in_data.dir_y;
				z_q <= in_data.dir_z;
				energy_q <= in_data.ray_energy;
				idx_q <= in_data.point_index;
				idx_ok_q <= idx_ok_w;
				j_q <= '0;
				c_q <= '0;
			end
			ST_READ_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.read_index <= idx_q;
					out_q.intensity <= idx_ok_q ? acc_rdata[39:0] : '0;
					out_q.saturated <= idx_ok_q && acc_rdata[40];
				end
			end
			ST_GE2: ge_q <= mul_q[47:0];
			ST_DOT_Y: dot_q <= $signed(mul_q[33:0]);
			ST_DOT_Z: dot_q <= dot_w;
			ST_DOT_CMP: begin
				dot_q <= dot_w;
				slot_q <= j_q[PTR_W-1:0];
				j_q <= j_nxt;
				c_q <= mode_q ? c_q : c_nxt;
			end
			ST_K_SQ: big_q <= mag_w[32:30] != 3'b000;
			ST_K_U: u_q <= big_q ? '0 : udiff_w[60:30];
			ST_K_E: begin
				ezero_q <= mul_q[61:50] != 12'b0;
				tabk_q <= EXP_TAB[{1'b0, k_w}];
				d_q <= EXP_TAB[{1'b0, k_w}] - EXP_TAB[{1'b0, k_w} + 9'd1];
				fr_q <= mul_q[41:30];
			end
			ST_K_EX: e16_q <= ezero_q ? '0 : e_w[30:14];
			ST_K_M2: t_q <= mul_q[40:0];
			ST_DIV: begin
				share_q <= div_quo;
				i_q <= '0;
			end
			ST_H_WR: i_q <= i_nxt;
			default: begin
			end
		endcase
	end
endmodule

// File: dv/ray_direction_intensity_binner_top_tb.sv
// Self-checking testbench of the ray direction intensity binner, with its own accumulator model.
`timescale 1ns / 100ps

module ray_direction_intensity_binner_top_tb;
	import rdib_pkg::*;

	localparam int N_SLOTS = 1024;
	localparam int N_LOADED = 64;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int HOLD_CYCLES = 2500;

	typedef struct {
		in_item_t item;
		bit has_exp;
		out_item_t exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic signed [15:0] dir_mem [0:N_SLOTS-1][0:2];
	logic [39:0] acc_mem [0:N_SLOTS-1];
	bit sat_mem [0:N_SLOTS-1];
	int hit_slots [0:N_SLOTS-1];
	int hit_total;
	longint unsigned exp_lut [0:EXP_TABLE_SIZE];

	bit mode_smooth;
	logic [10:0] pts_in_use;
	logic signed [15:0] hard_thr;
	logic signed [15:0] kern_thr;
	logic [31:0] gain_reg;
	logic [31:0] inv_width_reg;

	out_item_t pending_reads [$];
	stim_row_t directed_rows [$];
	int fail_count = 0;
	int idle_cycles = 0;
	int reads_seen = 0;
	int rays_sent = 0;
	int phases_run = 0;
	bit hold_off = 1'b0;
	bit no_idle = 1'b0;

	ray_direction_intensity_binner_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void build_exp_lut();
		longint unsigned h, sum, t;
		h = (longint'(EXP_SPAN) << 30) / EXP_TABLE_SIZE;
		sum = 64'd1 << 30;
		t = 64'd1 << 30;
		for (int n = 1; n <= 24; n++) begin
			t = ((t * h) >> 30) / n;
			if (n % 2 == 1) begin
				sum = (sum > t) ? sum - t : 0;
			end else begin
				sum += t;
			end
		end
		exp_lut[0] = 64'd1 << 30;
		for (int k = 1; k <= EXP_TABLE_SIZE; k++) begin
			exp_lut[k] = (exp_lut[k-1] * sum + (64'd1 << 29)) >> 30;
		end
	endfunction

	function automatic longint unsigned decay(longint unsigned a16);
		longint unsigned span, p, k, f, d;
		span = longint'(EXP_SPAN) << 16;
		p = a16 * EXP_TABLE_SIZE;
		k = p / span;
		f = p % span;
		if (k >= EXP_TABLE_SIZE) begin
			return 0;
		end
		d = exp_lut[k] - exp_lut[k+1];
		return exp_lut[k] - (d * f) / span;
	endfunction

	function automatic void deposit(int slot, longint unsigned amount);
		longint unsigned s;
		s = longint'(acc_mem[slot]) + amount;
		if (amount > longint'(ACC_MAX) || s > longint'(ACC_MAX)) begin
			s = ACC_MAX;
			sat_mem[slot] = 1'b1;
		end
		acc_mem[slot] = s[39:0];
	endfunction

	function automatic longint dot_with(in_item_t it, int j);
		return longint'(it.dir_x) * dir_mem[j][0] + longint'(it.dir_y) * dir_mem[j][1] +
			longint'(it.dir_z) * dir_mem[j][2];
	endfunction

	// Updates the model state for one accepted item; returns 1 with the result for a read.
	function automatic bit bin_item(in_item_t it, output out_item_t r);
		int n;
		longint thr, dp;
		longint unsigned m, sq, u30, a16, e16, ge, share;
		r = '0;
		n = (pts_in_use > N_SLOTS) ? N_SLOTS : pts_in_use;
		case (it.opcode)
			OP_LOAD: begin
				dir_mem[it.point_index][0] = it.dir_x;
				dir_mem[it.point_index][1] = it.dir_y;
				dir_mem[it.point_index][2] = it.dir_z;
				return 1'b0;
			end
			OP_READ: begin
				r.read_index = it.point_index;
				r.intensity = acc_mem[it.point_index];
				r.saturated = sat_mem[it.point_index];
				return 1'b1;
			end
			OP_RAY: begin
				if (!mode_smooth) begin
					thr = longint'(hard_thr) * 32768;
					hit_total = 0;
					for (int j = 0; j < n; j++) begin
						if (dot_with(it, j) > thr) begin
							hit_slots[hit_total] = j;
							hit_total++;
						end
					end
					if (hit_total > 0) begin
						share = (longint'(it.ray_energy) << 8) / hit_total;
						for (int j = 0; j < hit_total; j++) begin
							deposit(hit_slots[j], share);
						end
					end
				end else begin
					thr = longint'(kern_thr) * 32768;
					ge = longint'(gain_reg) * it.ray_energy;
					for (int j = 0; j < n; j++) begin
						dp = dot_with(it, j);
						if (dp > thr) begin
							m = (dp < 0) ? -dp : dp;
							sq = m * m;
							u30 = (((64'd1 << 60) > sq) ? (64'd1 << 60) - sq : 0) >> 30;
							a16 = (u30 * inv_width_reg) >> 30;
							e16 = decay(a16) >> 14;
							deposit(j, (ge * e16) >> 24);
						end
					end
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int gap_draw();
		return no_idle ? 0 : $urandom_range(0, 11);
	endfunction

	task automatic offer(in_item_t it, bit has_exp, out_item_t typed);
		int gap;
		out_item_t r;
		gap = gap_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (bin_item(it, r)) begin
			pending_reads.push_back(has_exp ? typed : r);
		end
		if (it.opcode == OP_RAY) begin
			rays_sent++;
		end
	endtask

	task automatic drain();
		in_item_t it;
		it = '0;
		it.opcode = OP_READ;
		offer(it, 1'b0, '0);
		in_valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_SMOOTHING_MODE: mode_smooth = val[0];
			CFG_POINT_COUNT: pts_in_use = val[10:0];
			CFG_HIT_THRESHOLD: hard_thr = val[15:0];
			CFG_SMOOTH_THRESHOLD: kern_thr = val[15:0];
			CFG_KERNEL_GAIN: gain_reg = val;
			CFG_KERNEL_INV_WIDTH: inv_width_reg = val;
			default: ;
		endcase
	endtask

	function automatic in_item_t cluster_dir();
		in_item_t it;
		logic signed [15:0] c [0:2];
		int ax;
		it = '0;
		ax = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			c[i] = 16'($urandom_range(0, 3000) - 1500);
		end
		c[ax] = 16'(32767 - $urandom_range(0, 50));
		if ($urandom_range(0, 1)) begin
			c[ax] = -c[ax];
		end
		it.dir_x = c[0];
		it.dir_y = c[1];
		it.dir_z = c[2];
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int sel, j, lim;
		sel = $urandom_range(0, 99);
		lim = (pts_in_use == 0) ? 1 : ((pts_in_use > N_SLOTS) ? N_SLOTS : pts_in_use);
		if (sel < 20) begin
			it = ($urandom_range(0, 4) == 0) ?
				in_item_t'({$urandom, $urandom, 12'($urandom)}) : cluster_dir();
			it.opcode = OP_LOAD;
			it.point_index = 10'($urandom);
		end else if (sel < 60) begin
			if ($urandom_range(0, 9) < 7) begin
				j = $urandom_range(0, lim - 1);
				it = cluster_dir();
				if ($urandom_range(0, 1)) begin
					it.dir_x = dir_mem[j][0];
					it.dir_y = dir_mem[j][1];
					it.dir_z = dir_mem[j][2];
				end
			end else begin
				it = in_item_t'({$urandom, $urandom, 12'($urandom)});
			end
			it.opcode = OP_RAY;
			case ($urandom_range(0, 5))
				0: it.ray_energy = 16'hFFFF;
				1: it.ray_energy = 16'h0000;
				default: it.ray_energy = 16'($urandom);
			endcase
		end else if (sel < 95) begin
			it = in_item_t'({$urandom, $urandom, 12'($urandom)});
			it.opcode = OP_READ;
			it.point_index = ($urandom_range(0, 3) == 0) ? 10'($urandom) :
				10'($urandom_range(0, lim - 1));
		end else begin
			it = in_item_t'({$urandom, $urandom, 12'($urandom)});
			it.opcode = 2'd3;
		end
		return it;
	endfunction

	function automatic void add_row(logic [1:0] op, logic [9:0] idx, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z, logic [15:0] e, bit has_exp,
			logic [39:0] acc, bit sat);
		stim_row_t row;
		row.item = {op, idx, x, y, z, e};
		row.has_exp = has_exp;
		row.exp = {idx, acc, sat};
		directed_rows.push_back(row);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("[ray_direction_intensity_binner_top] ERROR");
					$finish;
				end
			end
		end
	end

	// Receiver: random stalls, with one long hold-off on request.
	initial begin
		int stall;
		out_item_t want;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				stall = HOLD_CYCLES;
				hold_off = 1'b0;
			end else begin
				stall = gap_draw();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			reads_seen++;
			if (pending_reads.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result %p", $time, out_data);
			end else begin
				want = pending_reads.pop_front();
				if (out_data.read_index !== want.read_index) begin
					fail_count++;
					$display("%0t: read_index expected %0d got %0d", $time,
						want.read_index, out_data.read_index);
				end
				if (out_data.intensity !== want.intensity) begin
					fail_count++;
					$display("%0t: intensity expected %0h got %0h", $time,
						want.intensity, out_data.intensity);
				end
				if (out_data.saturated !== want.saturated) begin
					fail_count++;
					$display("%0t: saturated expected %0b got %0b", $time,
						want.saturated, out_data.saturated);
				end
			end
		end
	end

	initial begin
		in_item_t it;
		logic [31:0] pc_pick, thr_pick, ks_pick, gain_pick, inv_pick;
		int n_items;
		build_exp_lut();
		mode_smooth = 1'b0;
		pts_in_use = 11'd1024;
		hard_thr = 16'sd32440;
		kern_thr = 16'sd29000;
		gain_reg = 32'd65536;
		inv_width_reg = 32'd65536;
		for (int i = 0; i < N_SLOTS; i++) begin
			acc_mem[i] = '0;
			sat_mem[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Only the slots in use are loaded, so no ray ever touches an unwritten direction.
		write_reg(CFG_POINT_COUNT, N_LOADED);
		no_idle = 1'b1;
		for (int i = 0; i < N_LOADED; i++) begin
			it = cluster_dir();
			it.opcode = OP_LOAD;
			it.point_index = 10'(i);
			offer(it, 1'b0, '0);
		end
		no_idle = 1'b0;

		add_row(OP_READ, 10'd0, 0, 0, 0, 0, 1'b1, 40'd0, 1'b0);
		add_row(OP_READ, 10'd1023, 0, 0, 0, 0, 1'b1, 40'd0, 1'b0);
		add_row(2'd3, 10'd5, -16'sd1, -16'sd1, -16'sd1, 16'hFFFF, 1'b0, 0, 0);
		add_row(OP_LOAD, 10'd61, -16'sd32768, -16'sd32768, -16'sd32768, 0, 1'b0, 0, 0);
		add_row(OP_LOAD, 10'd62, 16'sd32767, 16'sd32767, 16'sd32767, 0, 1'b0, 0, 0);
		add_row(OP_LOAD, 10'd63, 0, 16'sd32767, 0, 0, 1'b0, 0, 0);
		add_row(OP_RAY, 10'd0, 0, 16'sd32767, 0, 16'hFFFF, 1'b0, 0, 0);
		add_row(OP_RAY, 10'd0, 16'sd32767, 16'sd32767, 16'sd32767, 16'h0000, 1'b0, 0, 0);
		add_row(OP_RAY, 10'd0, -16'sd32768, -16'sd32768, -16'sd32768, 16'h0001, 1'b0, 0, 0);
		add_row(OP_RAY, 10'd0, 0, 0, 0, 16'hFFFF, 1'b0, 0, 0);
		add_row(OP_READ, 10'd63, 0, 0, 0, 0, 1'b0, 0, 0);
		add_row(OP_READ, 10'd62, 0, 0, 0, 0, 1'b0, 0, 0);
		add_row(OP_READ, 10'd61, 0, 0, 0, 0, 1'b0, 0, 0);
		add_row(OP_READ, 10'd0, 0, 0, 0, 0, 1'b0, 0, 0);
		foreach (directed_rows[i]) begin
			offer(directed_rows[i].item, directed_rows[i].has_exp, directed_rows[i].exp);
		end

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			case (ph % 6)
				0: pc_pick = 1;
				1: pc_pick = 0;
				2: pc_pick = N_LOADED;
				default: pc_pick = $urandom_range(2, 24);
			endcase
			case (ph % 4)
				0: thr_pick = 32'h8000;
				1: thr_pick = 32'h7FFF;
				2: thr_pick = 32'd32440;
				default: thr_pick = $urandom_range(28000, 32767);
			endcase
			case (ph % 3)
				0: begin
					gain_pick = 32'hFFFF_FFFF;
					inv_pick = 32'd0;
				end
				1: begin
					gain_pick = 32'd0;
					inv_pick = 32'hFFFF_FFFF;
				end
				default: begin
					gain_pick = $urandom;
					inv_pick = $urandom_range(0, 32'h0040_0000);
				end
			endcase
			ks_pick = (ph == 3) ? 32'h8000 : ((ph == 9) ? 32'h7FFF : $urandom_range(20000, 32000));
			write_reg(CFG_SMOOTHING_MODE, ph % 2);
			write_reg(CFG_POINT_COUNT, pc_pick);
			write_reg(CFG_HIT_THRESHOLD, thr_pick);
			write_reg(CFG_SMOOTH_THRESHOLD, ks_pick);
			write_reg(CFG_KERNEL_GAIN, gain_pick);
			write_reg(CFG_KERNEL_INV_WIDTH, inv_pick);
			phases_run++;
			no_idle = (ph % 4 == 3);
			n_items = 15;
			if (ph == 5) begin
				hold_off = 1'b1;
				no_idle = 1'b1;
				it = '0;
				it.opcode = OP_READ;
				for (int i = 0; i < 10; i++) begin
					it.point_index = 10'($urandom);
					offer(it, 1'b0, '0);
				end
				no_idle = 1'b0;
			end
			for (int i = 0; i < n_items; i++) begin
				offer(random_item(), 1'b0, '0);
			end
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Covered %0d phases of register settings, %0d rays and %0d read results.",
			phases_run, rays_sent, reads_seen);
		if (fail_count == 0 && pending_reads.size() == 0) begin
			$display("[ray_direction_intensity_binner_top] OK");
		end else begin
			$display("[ray_direction_intensity_binner_top] ERROR");
		end
		$finish;
	end

endmodule
